FILE: rtl/pidh_pkg.sv
package pidh_pkg;

  localparam int unsigned AngleW = 24;
  localparam int unsigned ErrW   = 25;
  localparam int unsigned DerW   = 26;
  localparam int unsigned GainW  = 16;
  localparam int unsigned ZoneW  = 23;
  localparam int unsigned PowW   = 15;
  localparam int unsigned DriveW = 16;
  localparam int unsigned ProdW  = 42;
  localparam int unsigned ProdDW = 43;
  localparam int unsigned AccW   = 44;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // error magnitude thresholds in 1/256 degree
  localparam logic [ErrW-1:0] DeadBand = 25'd384;
  localparam logic [ErrW-1:0] DoneBand = 25'd256;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainP  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainI  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainD  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgZone   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBound  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaxPow = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgMinPow = 3'd7;

  localparam logic [ZoneW-1:0] ZoneRst   = 23'd5120;
  localparam logic [ZoneW-1:0] BoundRst  = 23'd3840;
  localparam logic [PowW-1:0]  MaxPowRst = 15'd25600;
  localparam logic [PowW-1:0]  MinPowRst = 15'd1280;

  typedef struct packed {
    logic active;   // error outside the deadband
    logic in_zone;  // error inside the integral zone and nonzero
    logic done;     // error within the done band
  } flags_t;

endpackage

FILE: rtl/pidh_front.sv
module pidh_front (
  input  logic                                      clk_i,
  input  logic                                      en_in_i,
  input  logic                                      en_err_i,
  input  logic signed [pidh_pkg::AngleW-1:0]        measured_angle_i,
  input  logic signed [pidh_pkg::AngleW-1:0]        target_i,
  input  logic        [pidh_pkg::ZoneW-1:0]         zone_i,
  output logic signed [pidh_pkg::ErrW-1:0]          err_o,
  output pidh_pkg::flags_t                          flags_o
);

  logic signed [pidh_pkg::AngleW-1:0] meas_q;
  logic signed [pidh_pkg::ErrW-1:0]   err_d, err_q;
  logic        [pidh_pkg::ErrW-1:0]   aerr;
  pidh_pkg::flags_t                   flags_d, flags_q;

  always_ff @(posedge clk_i) begin
    if (en_in_i) begin
      meas_q <= measured_angle_i;
    end
  end

  always_comb begin
    err_d = {target_i[pidh_pkg::AngleW-1], target_i} - {meas_q[pidh_pkg::AngleW-1], meas_q};
    aerr  = err_d[pidh_pkg::ErrW-1] ? (~err_d + 25'd1) : err_d;
    flags_d.active  = aerr > pidh_pkg::DeadBand;
    flags_d.in_zone = (aerr < {2'b00, zone_i}) && (aerr != '0);
    flags_d.done    = aerr <= pidh_pkg::DoneBand;
  end

  always_ff @(posedge clk_i) begin
    if (en_err_i) begin
      err_q   <= err_d;
      flags_q <= flags_d;
    end
  end

  assign err_o   = err_q;
  assign flags_o = flags_q;

endmodule

FILE: rtl/pidh_integ.sv
module pidh_integ (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                upd_i,
  input  logic signed [pidh_pkg::ErrW-1:0]    err_i,
  input  pidh_pkg::flags_t                    flags_i,
  input  logic        [pidh_pkg::GainW-1:0]   gain_int_i,
  input  logic        [pidh_pkg::ZoneW-1:0]   bound_i,
  output logic signed [pidh_pkg::ErrW-1:0]    err_o,
  output logic signed [pidh_pkg::DerW-1:0]    deriv_o,
  output logic signed [pidh_pkg::ErrW-1:0]    integ_o,
  output pidh_pkg::flags_t                    flags_o
);

  logic signed [pidh_pkg::ErrW-1:0] last_err_q, integ_q, integ_d, sat, pos_b, neg_b;
  logic signed [pidh_pkg::ErrW:0]   sum;
  logic signed [pidh_pkg::DerW-1:0] deriv_d;
  logic signed [pidh_pkg::ErrW-1:0] err_q, integ_out_q;
  logic signed [pidh_pkg::DerW-1:0] deriv_q;
  pidh_pkg::flags_t                 flags_q;

  always_comb begin
    sum   = {err_i[pidh_pkg::ErrW-1], err_i} + {integ_q[pidh_pkg::ErrW-1], integ_q};
    pos_b = $signed({2'b00, bound_i});
    neg_b = -pos_b;
    // 25-bit saturation of the accumulator
    if (sum[pidh_pkg::ErrW] != sum[pidh_pkg::ErrW-1]) begin
      sat = sum[pidh_pkg::ErrW] ? {1'b1, {(pidh_pkg::ErrW-1){1'b0}}}
                                : {1'b0, {(pidh_pkg::ErrW-1){1'b1}}};
    end else begin
      sat = sum[pidh_pkg::ErrW-1:0];
    end
    if (!flags_i.active) begin
      integ_d = integ_q;
    end else begin
      integ_d = flags_i.in_zone ? sat : '0;
      if (gain_int_i != '0) begin
        if (integ_d > pos_b) begin
          integ_d = pos_b;
        end else if (integ_d < neg_b) begin
          integ_d = neg_b;
        end
      end
    end
    deriv_d = {err_i[pidh_pkg::ErrW-1], err_i} - {last_err_q[pidh_pkg::ErrW-1], last_err_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
    end else if (upd_i) begin
      last_err_q <= err_i;
      integ_q    <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_q       <= err_i;
      deriv_q     <= deriv_d;
      integ_out_q <= integ_d;
      flags_q     <= flags_i;
    end
  end

  assign err_o   = err_q;
  assign deriv_o = deriv_q;
  assign integ_o = integ_out_q;
  assign flags_o = flags_q;

endmodule

FILE: rtl/pidh_mult.sv
module pidh_mult (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic        [pidh_pkg::GainW-1:0]    gain_p_i,
  input  logic        [pidh_pkg::GainW-1:0]    gain_int_i,
  input  logic        [pidh_pkg::GainW-1:0]    gain_d_i,
  input  logic signed [pidh_pkg::ErrW-1:0]     err_i,
  input  logic signed [pidh_pkg::DerW-1:0]     deriv_i,
  input  logic signed [pidh_pkg::ErrW-1:0]     integ_i,
  input  pidh_pkg::flags_t                     flags_i,
  output logic signed [pidh_pkg::ProdW-1:0]    prod_p_o,
  output logic signed [pidh_pkg::ProdW-1:0]    prod_i_o,
  output logic signed [pidh_pkg::ProdDW-1:0]   prod_d_o,
  output logic signed [pidh_pkg::ErrW-1:0]     err_o,
  output pidh_pkg::flags_t                     flags_o
);

  logic signed [pidh_pkg::ProdW-1:0]  prod_p_q, prod_i_q;
  logic signed [pidh_pkg::ProdDW-1:0] prod_d_q;
  logic signed [pidh_pkg::ErrW-1:0]   err_q;
  pidh_pkg::flags_t                   flags_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_p_q <= $signed({1'b0, gain_p_i}) * err_i;
      prod_i_q <= $signed({1'b0, gain_int_i}) * integ_i;
      prod_d_q <= $signed({1'b0, gain_d_i}) * deriv_i;
      err_q    <= err_i;
      flags_q  <= flags_i;
    end
  end

  assign prod_p_o = prod_p_q;
  assign prod_i_o = prod_i_q;
  assign prod_d_o = prod_d_q;
  assign err_o    = err_q;
  assign flags_o  = flags_q;

endmodule

FILE: rtl/pidh_drive.sv
module pidh_drive (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [pidh_pkg::ProdW-1:0]    prod_p_i,
  input  logic signed [pidh_pkg::ProdW-1:0]    prod_i_i,
  input  logic signed [pidh_pkg::ProdDW-1:0]   prod_d_i,
  input  logic signed [pidh_pkg::ErrW-1:0]     err_i,
  input  pidh_pkg::flags_t                     flags_i,
  input  logic        [pidh_pkg::PowW-1:0]     max_power_i,
  input  logic        [pidh_pkg::PowW-1:0]     min_power_i,
  output logic signed [pidh_pkg::DriveW-1:0]   drive_o,
  output logic                                 done_o,
  output logic signed [pidh_pkg::ErrW-1:0]     err_o
);

  localparam int unsigned PwrW = pidh_pkg::AccW - 8;

  logic signed [pidh_pkg::AccW-1:0]   acc;
  logic signed [PwrW-1:0]             pwr, maxp;
  logic signed [pidh_pkg::DriveW-1:0] power, minp, drive_d, drive_q;
  logic        [pidh_pkg::DriveW-1:0] mag;
  logic                               done_q;
  logic signed [pidh_pkg::ErrW-1:0]   err_q;

  always_comb begin
    acc = {{2{prod_p_i[pidh_pkg::ProdW-1]}}, prod_p_i}
        + {{2{prod_i_i[pidh_pkg::ProdW-1]}}, prod_i_i}
        + {prod_d_i[pidh_pkg::ProdDW-1], prod_d_i};
    // arithmetic shift is the floor of the division by 256
    pwr  = acc[pidh_pkg::AccW-1:8];
    maxp = $signed({{(PwrW-pidh_pkg::PowW){1'b0}}, max_power_i});
    if (!flags_i.active) begin
      power = '0;
    end else if (pwr > maxp) begin
      power = $signed({1'b0, max_power_i});
    end else if (pwr < -maxp) begin
      power = -$signed({1'b0, max_power_i});
    end else begin
      power = pwr[pidh_pkg::DriveW-1:0];
    end
    minp = $signed({1'b0, min_power_i});
    mag  = power[pidh_pkg::DriveW-1] ? (~power + 16'd1) : power;
    if (flags_i.done) begin
      drive_d = '0;
    end else if (mag < {1'b0, min_power_i}) begin
      drive_d = power[pidh_pkg::DriveW-1] ? -minp : minp;
    end else begin
      drive_d = power;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q <= drive_d;
      done_q  <= flags_i.done;
      err_q   <= err_i;
    end
  end

  assign drive_o = drive_q;
  assign done_o  = done_q;
  assign err_o   = err_q;

endmodule

FILE: rtl/pid_heading_controller.sv
// an accepted word passes through the input, error, integral, multiply and output registers to the outputs
// throughput: one word per cycle while the receiver takes words; the five-register pipeline stalls when it does not
// the integral and last error are updated in a single stage, so back-to-back words chain
// reset: configuration returns to its defaults, integral and last error clear to zero,
// and the pipeline empties
module pid_heading_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [pidh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [pidh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [pidh_pkg::AngleW-1:0]   measured_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pidh_pkg::DriveW-1:0]   drive_o,
  output logic                                 done_res_o,
  output logic signed [pidh_pkg::ErrW-1:0]     current_error_o
);

  logic signed [pidh_pkg::AngleW-1:0] target_q;
  logic [pidh_pkg::GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [pidh_pkg::ZoneW-1:0] zone_q, bound_q;
  logic [pidh_pkg::PowW-1:0]  max_pow_q, min_pow_q;

  logic v_in_q, v_err_q, v_int_q, v_mul_q, v_out_q;
  logic en_in, en_err, en_int, en_mul, en_out;

  logic signed [pidh_pkg::ErrW-1:0]   f_err, i_err, i_integ, m_err;
  logic signed [pidh_pkg::DerW-1:0]   i_deriv;
  logic signed [pidh_pkg::ProdW-1:0]  m_prod_p, m_prod_i;
  logic signed [pidh_pkg::ProdDW-1:0] m_prod_d;
  pidh_pkg::flags_t f_flags, i_flags, m_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      zone_q    <= pidh_pkg::ZoneRst;
      bound_q   <= pidh_pkg::BoundRst;
      max_pow_q <= pidh_pkg::MaxPowRst;
      min_pow_q <= pidh_pkg::MinPowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pidh_pkg::CfgTarget: target_q  <= cfg_data_i[pidh_pkg::AngleW-1:0];
        pidh_pkg::CfgGainP:  gain_p_q  <= cfg_data_i[pidh_pkg::GainW-1:0];
        pidh_pkg::CfgGainI:  gain_i_q  <= cfg_data_i[pidh_pkg::GainW-1:0];
        pidh_pkg::CfgGainD:  gain_d_q  <= cfg_data_i[pidh_pkg::GainW-1:0];
        pidh_pkg::CfgZone:   zone_q    <= cfg_data_i[pidh_pkg::ZoneW-1:0];
        pidh_pkg::CfgBound:  bound_q   <= cfg_data_i[pidh_pkg::ZoneW-1:0];
        pidh_pkg::CfgMaxPow: max_pow_q <= cfg_data_i[pidh_pkg::PowW-1:0];
        pidh_pkg::CfgMinPow: min_pow_q <= cfg_data_i[pidh_pkg::PowW-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its word moves on
  assign en_out = !v_out_q || out_ready_i;
  assign en_mul = !v_mul_q || en_out;
  assign en_int = !v_int_q || en_mul;
  assign en_err = !v_err_q || en_int;
  assign en_in  = !v_in_q  || en_err;
  assign in_ready_o = en_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_err_q <= 1'b0;
      v_int_q <= 1'b0;
      v_mul_q <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (en_in)  v_in_q  <= in_valid_i;
      if (en_err) v_err_q <= v_in_q;
      if (en_int) v_int_q <= v_err_q;
      if (en_mul) v_mul_q <= v_int_q;
      if (en_out) v_out_q <= v_mul_q;
    end
  end

  pidh_front u_front (
    .clk_i            (clk_i),
    .en_in_i          (en_in),
    .en_err_i         (en_err),
    .measured_angle_i (measured_angle_i),
    .target_i         (target_q),
    .zone_i           (zone_q),
    .err_o            (f_err),
    .flags_o          (f_flags)
  );

  pidh_integ u_integ (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_int),
    .upd_i      (en_int && v_err_q),
    .err_i      (f_err),
    .flags_i    (f_flags),
    .gain_int_i (gain_i_q),
    .bound_i    (bound_q),
    .err_o      (i_err),
    .deriv_o    (i_deriv),
    .integ_o    (i_integ),
    .flags_o    (i_flags)
  );

  pidh_mult u_mult (
    .clk_i      (clk_i),
    .en_i       (en_mul),
    .gain_p_i   (gain_p_q),
    .gain_int_i (gain_i_q),
    .gain_d_i   (gain_d_q),
    .err_i      (i_err),
    .deriv_i    (i_deriv),
    .integ_i    (i_integ),
    .flags_i    (i_flags),
    .prod_p_o   (m_prod_p),
    .prod_i_o   (m_prod_i),
    .prod_d_o   (m_prod_d),
    .err_o      (m_err),
    .flags_o    (m_flags)
  );

  pidh_drive u_drive (
    .clk_i       (clk_i),
    .en_i        (en_out),
    .prod_p_i    (m_prod_p),
    .prod_i_i    (m_prod_i),
    .prod_d_i    (m_prod_d),
    .err_i       (m_err),
    .flags_i     (m_flags),
    .max_power_i (max_pow_q),
    .min_power_i (min_pow_q),
    .drive_o     (drive_o),
    .done_o      (done_res_o),
    .err_o       (current_error_o)
  );

  assign out_valid_o = v_out_q;

`ifndef SYNTHESIS
  a_done_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> drive_o == '0)
    else $error("done word carries nonzero drive");

  a_done_small_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |->
      (current_error_o <= 25'sd256) && (current_error_o >= -25'sd256))
    else $error("done flagged with large error");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_o != {1'b1, {(pidh_pkg::DriveW-1){1'b0}}})
    else $error("drive outside symmetric range");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_in_q && v_err_q && v_int_q && v_mul_q && v_out_q && !out_ready_i)
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

FILE: sim/tb_pid_heading_controller.sv
`timescale 1ns / 1ps

module tb_pid_heading_controller;

  localparam int Phases     = 12;
  localparam int PhaseWords = 140;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;
  localparam longint ErrMax = (longint'(1) <<< (pidh_pkg::ErrW - 1)) - 1;
  localparam longint ErrMin = -(longint'(1) <<< (pidh_pkg::ErrW - 1));

  typedef struct packed {
    logic signed [pidh_pkg::DriveW-1:0] drive;
    logic                               done;
    logic signed [pidh_pkg::ErrW-1:0]   err;
  } turn_res_t;

  typedef enum logic {RowItem, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [pidh_pkg::CfgIdxW-1:0]    idx;
    logic [pidh_pkg::CfgDataW-1:0]   val;
    bit                              typed;
    turn_res_t                       res;
  } step_row_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [pidh_pkg::CfgIdxW-1:0]         cfg_index_i;
  logic [pidh_pkg::CfgDataW-1:0]        cfg_data_i;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [pidh_pkg::AngleW-1:0]   measured_angle_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [pidh_pkg::DriveW-1:0]   drive_o;
  logic                                 done_res_o;
  logic signed [pidh_pkg::ErrW-1:0]     current_error_o;

  // controller shadow: configuration and loop state
  logic signed [pidh_pkg::AngleW-1:0] tgt   = '0;
  logic [pidh_pkg::GainW-1:0]         kp    = '0;
  logic [pidh_pkg::GainW-1:0]         ki    = '0;
  logic [pidh_pkg::GainW-1:0]         kd    = '0;
  logic [pidh_pkg::ZoneW-1:0]         zone  = pidh_pkg::ZoneRst;
  logic [pidh_pkg::ZoneW-1:0]         bound = pidh_pkg::BoundRst;
  logic [pidh_pkg::PowW-1:0]          pmax  = pidh_pkg::MaxPowRst;
  logic [pidh_pkg::PowW-1:0]          pmin  = pidh_pkg::MinPowRst;
  longint                             last_err = 0;
  longint                             integ    = 0;

  turn_res_t   pending_turns[$];
  step_row_t   plan[$];
  longint      walk_err     = 0;
  int          gap_pct      = 0;
  int          rx_stall_pct = 0;
  bit          rx_hold_req  = 1'b0;
  int          bad_fields   = 0;
  int          stall_cycles = 0;

  pid_heading_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .measured_angle_i (measured_angle_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_o          (drive_o),
    .done_res_o       (done_res_o),
    .current_error_o  (current_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic turn_res_t predict_turn(
      input logic signed [pidh_pkg::AngleW-1:0] meas);
    longint    err, aerr, prev, acc, pwr, drv;
    turn_res_t r;
    err      = longint'(tgt) - longint'(meas);
    aerr     = (err < 0) ? -err : err;
    prev     = last_err;
    last_err = err;
    pwr      = 0;
    if (aerr > longint'(pidh_pkg::DeadBand)) begin
      if (aerr < longint'(zone) && aerr != 0) begin
        integ = integ + err;
        if (integ > ErrMax) integ = ErrMax;
        if (integ < ErrMin) integ = ErrMin;
      end else begin
        integ = 0;
      end
      // bound only applies while the integral gain is in use
      if (ki != 0) begin
        if (integ > longint'(bound)) integ = longint'(bound);
        else if (integ < -longint'(bound)) integ = -longint'(bound);
      end
      acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * (err - prev);
      pwr = acc >>> 8;
      if (pwr > longint'(pmax)) pwr = longint'(pmax);
      else if (pwr < -longint'(pmax)) pwr = -longint'(pmax);
    end
    r.done = (aerr <= longint'(pidh_pkg::DoneBand));
    if (r.done) begin
      drv = 0;
    end else begin
      drv = pwr;
      // zero power counts as positive for the minimum drive
      if (((drv < 0) ? -drv : drv) < longint'(pmin)) begin
        drv = (drv < 0) ? -longint'(pmin) : longint'(pmin);
      end
    end
    r.drive = drv[pidh_pkg::DriveW-1:0];
    r.err   = err[pidh_pkg::ErrW-1:0];
    return r;
  endfunction

  function automatic void add_write(input logic [pidh_pkg::CfgIdxW-1:0] idx,
                                    input logic [pidh_pkg::CfgDataW-1:0] val);
    plan.push_back('{RowWrite, idx, val, 1'b0, '0});
  endfunction

  function automatic void add_item(input int m);
    plan.push_back('{RowItem, '0, 24'(m), 1'b0, '0});
  endfunction

  function automatic void add_typed(input int m, input int drv, input bit dn, input int er);
    plan.push_back('{RowItem, '0, 24'(m), 1'b1, '{drive: 16'(drv), done: dn, err: 25'(er)}});
  endfunction

  function automatic logic [pidh_pkg::CfgDataW-1:0] pick_gain();
    case ($urandom_range(4)) inside
      0:       return '0;
      1:       return 24'hFFFF;
      [2:3]:   return 24'($urandom_range(1024, 16));
      default: return 24'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [pidh_pkg::CfgDataW-1:0] pick_span();
    case ($urandom_range(4)) inside
      0:       return '0;
      1:       return 24'h7FFFFF;
      [2:3]:   return 24'($urandom_range(20000, 1));
      default: return 24'($urandom_range(23'h7FFFFF));
    endcase
  endfunction

  function automatic logic [pidh_pkg::CfgDataW-1:0] pick_power(input int top);
    case ($urandom_range(3))
      0:       return '0;
      1:       return 24'h7FFF;
      default: return 24'($urandom_range(top));
    endcase
  endfunction

  // turns that settle toward the target, mixed with near, wide and wild samples
  function automatic logic [pidh_pkg::AngleW-1:0] next_heading();
    longint      e;
    int unsigned span;
    int unsigned pick;
    span = zone;
    span = span + span / 4 + 500;
    pick = $urandom_range(9);
    if (pick == 9) return 24'($urandom);
    if (pick >= 5) begin
      if (walk_err < 64 && walk_err > -64) begin
        walk_err = longint'($urandom_range(span * 2));
        if ($urandom_range(1)) walk_err = -walk_err;
      end
      walk_err = walk_err - walk_err / 4 + longint'($urandom_range(64)) - 32;
      e = walk_err;
    end else begin
      e = longint'($urandom_range(pick < 3 ? 1200 : span));
      if ($urandom_range(1)) e = -e;
    end
    return 24'(longint'(tgt) - e);
  endfunction

  task automatic send_heading(input logic [pidh_pkg::AngleW-1:0] meas, input bit typed,
                              input turn_res_t given);
    turn_res_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    measured_angle_i <= meas;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_turn(meas);
    pending_turns.push_back(typed ? given : r);
  endtask

  task automatic rest_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_turns.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pidh_pkg::CfgIdxW-1:0] idx,
                           input logic [pidh_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      pidh_pkg::CfgTarget: tgt   = val[pidh_pkg::AngleW-1:0];
      pidh_pkg::CfgGainP:  kp    = val[pidh_pkg::GainW-1:0];
      pidh_pkg::CfgGainI:  ki    = val[pidh_pkg::GainW-1:0];
      pidh_pkg::CfgGainD:  kd    = val[pidh_pkg::GainW-1:0];
      pidh_pkg::CfgZone:   zone  = val[pidh_pkg::ZoneW-1:0];
      pidh_pkg::CfgBound:  bound = val[pidh_pkg::ZoneW-1:0];
      pidh_pkg::CfgMaxPow: pmax  = val[pidh_pkg::PowW-1:0];
      pidh_pkg::CfgMinPow: pmin  = val[pidh_pkg::PowW-1:0];
      default: ;
    endcase
  endtask

  // receiver side
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    turn_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_turns.size() == 0) begin
        bad_fields++;
        $display("%0t: unexpected word drive %0d done %0d error %0d",
                 $time, drive_o, done_res_o, current_error_o);
      end else begin
        want = pending_turns.pop_front();
        if (drive_o !== want.drive) begin
          bad_fields++;
          $display("%0t: drive expected %0d got %0d", $time, want.drive, drive_o);
        end
        if (done_res_o !== want.done) begin
          bad_fields++;
          $display("%0t: done expected %0d got %0d", $time, want.done, done_res_o);
        end
        if (current_error_o !== want.err) begin
          bad_fields++;
          $display("%0t: error expected %0d got %0d", $time, want.err, current_error_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("pid_heading_controller: mismatch");
      $finish;
    end
  end

  initial begin
    step_row_t row;
    bit        hi, lo;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    measured_angle_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero gains, so every active word gets the minimum drive
    add_typed(0, 0, 1'b1, 0);
    add_typed(-256, 0, 1'b1, 256);
    add_typed(257, 1280, 1'b0, -257);
    add_typed(-8388608, 1280, 1'b0, 8388608);
    add_typed(8388607, 1280, 1'b0, -8388607);
    add_write(pidh_pkg::CfgTarget, 24'h7FFFFF);
    add_typed(-8388608, 1280, 1'b0, 16777215);
    add_write(pidh_pkg::CfgTarget, 24'h800000);
    add_typed(8388607, 1280, 1'b0, -16777215);
    // zone, clamp, clear outside the zone, deadband hold, saturation
    add_write(pidh_pkg::CfgTarget, 24'h0);
    add_write(pidh_pkg::CfgGainP, 24'd256);
    add_write(pidh_pkg::CfgGainI, 24'd256);
    add_write(pidh_pkg::CfgGainD, 24'd256);
    add_write(pidh_pkg::CfgBound, 24'd1000);
    add_item(-1000);
    add_item(-1000);
    add_item(1000);
    add_item(-6000);
    add_item(-300);
    add_item(8388607);
    add_write(pidh_pkg::CfgGainP, 24'hFFFF);
    add_write(pidh_pkg::CfgGainD, 24'hFFFF);
    add_write(pidh_pkg::CfgMaxPow, 24'h7FFF);
    add_write(pidh_pkg::CfgMinPow, 24'h0);
    add_item(-8388608);
    add_item(8388607);
    add_write(pidh_pkg::CfgMaxPow, 24'h0);
    add_write(pidh_pkg::CfgMinPow, 24'h7FFF);
    add_item(500);
    add_write(pidh_pkg::CfgMaxPow, 24'h7FFF);
    add_write(pidh_pkg::CfgMinPow, 24'd2000);
    add_write(pidh_pkg::CfgGainP, 24'd256);
    add_write(pidh_pkg::CfgGainI, 24'h0);
    add_write(pidh_pkg::CfgGainD, 24'h0);
    add_item(1000);
    // integral runs into its rails with the clamp off, then gets clamped
    add_write(pidh_pkg::CfgZone, 24'h7FFFFF);
    add_write(pidh_pkg::CfgTarget, 24'h7FFFFF);
    repeat (3) add_item(1);
    add_write(pidh_pkg::CfgGainI, 24'd1);
    add_write(pidh_pkg::CfgBound, 24'h7FFFFF);
    add_item(1);
    add_write(pidh_pkg::CfgGainI, 24'h0);
    add_write(pidh_pkg::CfgTarget, 24'h800000);
    repeat (4) add_item(-2);
    add_write(pidh_pkg::CfgGainI, 24'd1);
    add_item(-2);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == RowWrite) begin
        rest_until_drained();
        write_reg(row.idx, row.val);
      end else begin
        send_heading(row.val, row.typed, row.res);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      rest_until_drained();
      hi = (p == 0);
      lo = (p == 1);
      write_reg(pidh_pkg::CfgTarget, hi ? 24'h7FFFFF : lo ? 24'h800000 : 24'($urandom));
      write_reg(pidh_pkg::CfgGainP,  hi ? 24'hFFFF : lo ? 24'h0 : pick_gain());
      write_reg(pidh_pkg::CfgGainI,  hi ? 24'hFFFF : lo ? 24'h0 : pick_gain());
      write_reg(pidh_pkg::CfgGainD,  hi ? 24'hFFFF : lo ? 24'h0 : pick_gain());
      write_reg(pidh_pkg::CfgZone,   hi ? 24'h7FFFFF : lo ? 24'h0 : pick_span());
      write_reg(pidh_pkg::CfgBound,  hi ? 24'h7FFFFF : lo ? 24'h0 : pick_span());
      write_reg(pidh_pkg::CfgMaxPow, hi ? 24'h7FFF : lo ? 24'h0 : pick_power(32767));
      write_reg(pidh_pkg::CfgMinPow, hi ? 24'h7FFF : lo ? 24'h0 : pick_power(4000));
      gap_pct      = (p % 4 == 1) ? 56 : (p % 4 == 3) ? 28 : 0;
      rx_stall_pct = (p % 4 == 2) ? 56 : (p % 4 == 3) ? 28 : 0;
      // long receiver hold while words keep coming, so the pipeline backs up
      if (p == 4) rx_hold_req = 1'b1;
      for (int n = 0; n < PhaseWords; n++) begin
        send_heading(next_heading(), 1'b0, '0);
      end
    end

    rest_until_drained();
    rx_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (bad_fields == 0) begin
      $display("pid_heading_controller: match");
    end else begin
      $display("pid_heading_controller: mismatch");
    end
    $finish;
  end

endmodule
